### sv/mtma_pkg.sv
// ----------------------------------------------------------------------------
// mtma_pkg
// Shared types and constants for the median / moving average filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtma_pkg;

	localparam int SAMPLE_W = 10;
	localparam int FRAC_W   = 4;
	localparam int FILT_W   = 14;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [FILT_W-1:0]   filt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK,
		ST_AVG,
		ST_MUL,
		ST_QUO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic rank_en;
		logic avg_en;
		logic mul_en;
		logic quo_en;
		logic out_load;
	} ctrl_t;

endpackage

`default_nettype wire

### sv/mtma_rank_unit.sv
// ----------------------------------------------------------------------------
// mtma_rank_unit
// Stable rank of one window entry against the whole window; flags the entry
// that lands on the median position of the sorted order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtma_rank_unit #(
	parameter int MED_DEPTH = 5
) (
	input  mtma_pkg::sample_t                     win [MED_DEPTH],
	input  logic [((MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1)-1:0] idx,
	output mtma_pkg::sample_t                     cand,
	output logic                                  is_mid
);
	import mtma_pkg::*;

	localparam int IW = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;

	logic [IW:0] cnt;

	assign cand = win[idx];

	// ties broken by position so every entry gets a distinct rank
	always_comb begin
		cnt = '0;
		for (int j = 0; j < MED_DEPTH; j++) begin
			if ((win[j] < cand) || ((win[j] == cand) && (IW'(j) < idx))) begin
				cnt = cnt + (IW+1)'(1);
			end
		end
	end

	assign is_mid = (cnt == (IW+1)'(MED_DEPTH / 2));

endmodule

`default_nettype wire

### sv/mtma_recip_mul.sv
// ----------------------------------------------------------------------------
// mtma_recip_mul
// Shared multiplier: total * 16 / AVG_DEPTH by an exact reciprocal product,
// product registered, quotient taken from the upper bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtma_recip_mul #(
	parameter int AVG_DEPTH = 8
) (
	input  logic            clk,
	input  logic            load,
	input  mtma_pkg::filt_t total,
	output mtma_pkg::filt_t quotient
);
	import mtma_pkg::*;

	localparam int NUM_W = FILT_W + FRAC_W;
	localparam int LOG_D = $clog2(AVG_DEPTH);
	localparam int SH    = NUM_W + LOG_D;
	localparam int PW    = NUM_W + SH + 1;
	// ceil(2^SH / D): exact floor division for any numerator below 2^NUM_W
	localparam logic [SH:0] RECIP =
		(SH+1)'(((64'd1 << SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

	logic [NUM_W-1:0] num;
	logic [PW-1:0]    prod_q;

	assign num = {total, {FRAC_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PW'(num) * PW'(RECIP);
		end
	end

	assign quotient = prod_q[SH+FILT_W-1:SH];

endmodule

`default_nettype wire

### sv/median_then_moving_average_filter.sv
// ----------------------------------------------------------------------------
// median_then_moving_average_filter
// Two-channel median filter followed by a moving average, 4 fraction bits.
// ----------------------------------------------------------------------------
//  channel  signals                                   dir
//  in       in_valid, in_ready, east_sample, west_sample   in
//  out      out_valid, out_ready, east_filtered, west_filtered out
//
//  A request is accepted only from idle: the rank unit checks one window
//  entry per cycle per channel, then the add, multiply and quotient steps
//  run once per channel, before the result load and the return to idle.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and only the final load stalls on out_ready.
//  Reset clears all windows, slots and totals at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module median_then_moving_average_filter #(
	parameter int MED_DEPTH = 5,
	parameter int AVG_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mtma_pkg::sample_t east_sample,
	input  mtma_pkg::sample_t west_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output mtma_pkg::filt_t   east_filtered,
	output mtma_pkg::filt_t   west_filtered
);
	import mtma_pkg::*;

	localparam int MIW = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;
	localparam int AW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

	state_t  state_q, state_nxt;
	ctrl_t   ctl;

	sample_t        med_win_q [2][MED_DEPTH];
	logic [MIW-1:0] med_slot_q [2];
	logic           med_full_q [2];
	sample_t        avg_win_q [2][AVG_DEPTH];
	logic [AW-1:0]  avg_slot_q [2];
	filt_t          tot_q [2];
	logic           avg_full_q [2];

	sample_t        samp_q [2];
	sample_t        med_q [2];
	filt_t          res_q [2];
	logic           pass_q;
	logic           ch_q;
	logic [MIW-1:0] idx_q;
	logic           out_valid_q;

	sample_t        in_samp [2];
	sample_t        rank_win [MED_DEPTH];
	sample_t        cand;
	logic           is_mid;
	sample_t        avg_v;
	sample_t        avg_old;
	filt_t          tot_nxt;
	filt_t          quotient;

	assign in_samp[0] = east_sample;
	assign in_samp[1] = west_sample;

	always_comb begin
		for (int i = 0; i < MED_DEPTH; i++) begin
			rank_win[i] = med_win_q[ch_q][i];
		end
	end

	mtma_rank_unit #(
		.MED_DEPTH(MED_DEPTH)
	) u_rank (
		.win    (rank_win),
		.idx    (idx_q),
		.cand   (cand),
		.is_mid (is_mid)
	);

	mtma_recip_mul #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_mul (
		.clk      (clk),
		.load     (ctl.mul_en),
		.total    (tot_q[ch_q]),
		.quotient (quotient)
	);

	// median stage passes the raw sample through until its window has filled
	assign avg_v   = med_full_q[ch_q] ? med_q[ch_q] : samp_q[ch_q];
	assign avg_old = avg_win_q[ch_q][avg_slot_q[ch_q]];
	assign tot_nxt = avg_full_q[ch_q]
		? (tot_q[ch_q] - FILT_W'(avg_old) + FILT_W'(avg_v))
		: (tot_q[ch_q] + FILT_W'(avg_v));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_RANK;
			end
			ST_RANK: begin
				if ((idx_q == MIW'(MED_DEPTH - 1)) && ch_q) state_nxt = ST_AVG;
			end
			ST_AVG: state_nxt = ST_MUL;
			ST_MUL: state_nxt = ST_QUO;
			ST_QUO: state_nxt = ch_q ? ST_DONE : ST_AVG;
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: ctl.in_ready = 1'b1;
			ST_RANK: ctl.rank_en  = 1'b1;
			ST_AVG:  ctl.avg_en   = 1'b1;
			ST_MUL:  ctl.mul_en   = 1'b1;
			ST_QUO:  ctl.quo_en   = 1'b1;
			ST_DONE: ctl.out_load = !out_valid_q || out_ready;
			default: ctl = '0;
		endcase
	end

	assign in_ready  = ctl.in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			idx_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				med_slot_q[c] <= '0;
				med_full_q[c] <= 1'b0;
				avg_slot_q[c] <= '0;
				avg_full_q[c] <= 1'b0;
				tot_q[c]      <= '0;
				for (int i = 0; i < MED_DEPTH; i++) med_win_q[c][i] <= '0;
				for (int i = 0; i < AVG_DEPTH; i++) avg_win_q[c][i] <= '0;
			end
		end else begin
			state_q <= state_nxt;

			if (ctl.in_ready && in_valid) begin
				for (int c = 0; c < 2; c++) begin
					med_win_q[c][med_slot_q[c]] <= in_samp[c];
					if (med_slot_q[c] == MIW'(MED_DEPTH - 1)) begin
						med_slot_q[c] <= '0;
						med_full_q[c] <= 1'b1;
					end else begin
						med_slot_q[c] <= med_slot_q[c] + MIW'(1);
					end
				end
			end

			if (ctl.rank_en) begin
				if (idx_q == MIW'(MED_DEPTH - 1)) begin
					idx_q <= '0;
					ch_q  <= ~ch_q;
				end else begin
					idx_q <= idx_q + MIW'(1);
				end
			end

			if (ctl.avg_en) begin
				pass_q                      <= !avg_full_q[ch_q];
				tot_q[ch_q]                 <= tot_nxt;
				avg_win_q[ch_q][avg_slot_q[ch_q]] <= avg_v;
				if (avg_slot_q[ch_q] == AW'(AVG_DEPTH - 1)) begin
					avg_slot_q[ch_q] <= '0;
					avg_full_q[ch_q] <= 1'b1;
				end else begin
					avg_slot_q[ch_q] <= avg_slot_q[ch_q] + AW'(1);
				end
			end

			if (ctl.quo_en) ch_q <= ~ch_q;

			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.in_ready && in_valid) begin
			samp_q[0] <= east_sample;
			samp_q[1] <= west_sample;
		end
		if (ctl.rank_en && is_mid) med_q[ch_q] <= cand;
		if (ctl.quo_en) res_q[ch_q] <= pass_q ? {avg_v, {FRAC_W{1'b0}}} : quotient;
		if (ctl.out_load) begin
			east_filtered <= res_q[0];
			west_filtered <= res_q[1];
		end
	end

`ifndef SYNTHESIS
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (idx_q == '0) && !ch_q)
		else $error("sequencer counters not cleared in idle");

	// average slots move one channel at a time, so they are checked only between requests
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(med_slot_q[0] == med_slot_q[1]) && (med_full_q[0] == med_full_q[1])
		&& (!in_ready || (avg_slot_q[0] == avg_slot_q[1])))
		else $error("east and west window positions diverged");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(med_slot_q[0] <= MIW'(MED_DEPTH - 1)) && (avg_slot_q[0] <= AW'(AVG_DEPTH - 1)))
		else $error("window slot out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(east_filtered)
		&& $stable(west_filtered))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
